@@ src/pfs_pkg.sv @@
`default_nettype none

package pfs_pkg;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int TIMER_W    = 16;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_POLL_PERIOD      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WORKFLOW_TIMEOUT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RETRY_DELAY      = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_EXIT_DELAY       = 2'd3;

    localparam logic [TIMER_W-1:0] POLL_PERIOD_RST      = 16'd300;
    localparam logic [TIMER_W-1:0] WORKFLOW_TIMEOUT_RST = 16'd10000;
    localparam logic [TIMER_W-1:0] RETRY_DELAY_RST      = 16'd350;
    localparam logic [TIMER_W-1:0] EXIT_DELAY_RST       = 16'd300;

    localparam int FLAG_FRONT = 0;
    localparam int FLAG_REAR  = 1;
    localparam int FLAG_FLASH = 2;
    localparam int FLAG_DIR   = 3;
    localparam int FLAG_FAULT = 4;
    localparam int FLAG_W     = 5;

    typedef logic [FLAG_W-1:0] flags_t;

    typedef enum logic [2:0] {
        STAGE_HALT   = 3'd0,
        STAGE_WAIT   = 3'd1,
        STAGE_FEED   = 3'd2,
        STAGE_OUT    = 3'd3,
        STAGE_NOTIFY = 3'd4,
        STAGE_EJECT  = 3'd5
    } stage_t;

    typedef struct packed {
        logic [TIMER_W-1:0] poll_period;
        logic [TIMER_W-1:0] workflow_timeout;
        logic [TIMER_W-1:0] retry_delay;
        logic [TIMER_W-1:0] exit_delay;
    } cfg_t;

    typedef struct packed {
        logic kind;
        logic sensor_entry;
        logic sensor_middle;
        logic sensor_exit;
        logic front_turning;
        logic rear_turning;
    } item_t;

    typedef struct packed {
        logic   awaiting_host;
        logic   jam_report;
        logic   out_of_paper_notice;
        logic   capture_request;
        flags_t flags;
        stage_t stage_now;
    } result_t;

endpackage

`default_nettype wire

@@ src/pfs_cfg_regs.sv @@
`default_nettype none

module pfs_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [pfs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [pfs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output pfs_pkg::cfg_t                       cfg
);
    import pfs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_POLL_PERIOD:      cfg_next.poll_period      = cfg_wdata;
                REG_WORKFLOW_TIMEOUT: cfg_next.workflow_timeout = cfg_wdata;
                REG_RETRY_DELAY:      cfg_next.retry_delay      = cfg_wdata;
                REG_EXIT_DELAY:       cfg_next.exit_delay       = cfg_wdata;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.poll_period      <= POLL_PERIOD_RST;
            cfg_reg.workflow_timeout <= WORKFLOW_TIMEOUT_RST;
            cfg_reg.retry_delay      <= RETRY_DELAY_RST;
            cfg_reg.exit_delay       <= EXIT_DELAY_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ src/pfs_step.sv @@
`default_nettype none

module pfs_step (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  pfs_pkg::cfg_t    cfg,
    input  wire logic  item_advance,
    input  pfs_pkg::item_t   item,
    output pfs_pkg::result_t result
);
    import pfs_pkg::*;

    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
    localparam logic [TIMER_W-1:0] TIMER_ONE = TIMER_W'(1);

    stage_t             stage_reg, stage_next;
    logic [TIMER_W-1:0] poll_timer_reg, poll_timer_next;
    logic [TIMER_W-1:0] refresh_reg, refresh_next;
    logic [TIMER_W-1:0] exit_cnt_reg, exit_cnt_next;
    logic               paused_reg, paused_next;
    flags_t             flags_reg, flags_next;
    logic               cap, oop, jam;
    logic               ent, mid, ext;

    function automatic logic [TIMER_W-1:0] at_least_one(input logic [TIMER_W-1:0] v);
        return (v == '0) ? TIMER_ONE : v;
    endfunction

    assign ent = item.sensor_entry;
    assign mid = item.sensor_middle;
    assign ext = item.sensor_exit;

    always_comb begin
        stage_next      = stage_reg;
        poll_timer_next = poll_timer_reg;
        refresh_next    = refresh_reg;
        exit_cnt_next   = exit_cnt_reg;
        paused_next     = paused_reg;
        flags_next      = flags_reg;
        cap             = 1'b0;
        oop             = 1'b0;
        jam             = 1'b0;

        if (item.kind) begin
            paused_next = 1'b0;
        end else begin
            if (poll_timer_next != TIMER_MAX) begin
                poll_timer_next = poll_timer_next + TIMER_ONE;
            end
            if (exit_cnt_reg != '0) begin
                exit_cnt_next = exit_cnt_reg - TIMER_ONE;
                if (exit_cnt_next == '0) begin
                    flags_next[FLAG_FRONT] = 1'b0;
                    flags_next[FLAG_REAR]  = 1'b0;
                    flags_next[FLAG_FLASH] = 1'b0;
                    stage_next             = STAGE_WAIT;
                end
            end else begin
                if (refresh_reg != '0) begin
                    refresh_next = refresh_reg - TIMER_ONE;
                    if (refresh_next == '0) begin
                        if (ent && mid && ext) begin
                            flags_next  = '0;
                            paused_next = 1'b0;
                            stage_next  = STAGE_WAIT;
                        end else begin
                            if (!ent || !mid) begin
                                flags_next[FLAG_FRONT] = 1'b1;
                            end
                            if (!ext) begin
                                flags_next[FLAG_REAR] = 1'b1;
                            end
                            refresh_next = at_least_one(cfg.retry_delay);
                        end
                    end
                end
                if (!paused_next && (poll_timer_next > cfg.poll_period)) begin
                    poll_timer_next = '0;
                    case (stage_next)
                        STAGE_WAIT: begin
                            flags_next[FLAG_DIR] = ~flags_next[FLAG_DIR];
                            if (!ent) begin
                                flags_next[FLAG_DIR]   = 1'b0;
                                flags_next[FLAG_FRONT] = 1'b1;
                                stage_next             = STAGE_FEED;
                                refresh_next = at_least_one(cfg.workflow_timeout);
                            end
                        end
                        STAGE_FEED: begin
                            if (!ext) begin
                                flags_next[FLAG_FRONT] = 1'b0;
                                flags_next[FLAG_FLASH] = 1'b1;
                                cap                    = 1'b1;
                                paused_next            = 1'b1;
                                stage_next             = STAGE_OUT;
                                refresh_next = at_least_one(cfg.workflow_timeout);
                            end
                        end
                        STAGE_OUT: begin
                            if (!flags_next[FLAG_FRONT] && !flags_next[FLAG_REAR]) begin
                                flags_next[FLAG_FRONT] = 1'b1;
                                flags_next[FLAG_REAR]  = 1'b1;
                            end
                            if (ent && mid) begin
                                flags_next[FLAG_FRONT] = 1'b0;
                                cap                    = 1'b1;
                                paused_next            = 1'b1;
                                stage_next             = STAGE_NOTIFY;
                                refresh_next = at_least_one(cfg.workflow_timeout);
                            end
                        end
                        STAGE_NOTIFY: begin
                            oop          = 1'b1;
                            stage_next   = STAGE_EJECT;
                            refresh_next = '0;
                        end
                        STAGE_EJECT: begin
                            if (ext) begin
                                if (cfg.exit_delay == '0) begin
                                    flags_next[FLAG_FRONT] = 1'b0;
                                    flags_next[FLAG_REAR]  = 1'b0;
                                    flags_next[FLAG_FLASH] = 1'b0;
                                    stage_next             = STAGE_WAIT;
                                end else begin
                                    exit_cnt_next = cfg.exit_delay;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    if ((exit_cnt_next == '0) && flags_next[FLAG_FRONT]
                            && flags_next[FLAG_REAR]) begin
                        if (!(item.front_turning && item.rear_turning)) begin
                            flags_next[FLAG_FAULT] = 1'b1;
                            jam                    = 1'b1;
                            stage_next             = STAGE_HALT;
                        end else begin
                            flags_next[FLAG_FAULT] = 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg      <= STAGE_HALT;
            poll_timer_reg <= '0;
            refresh_reg    <= TIMER_ONE;
            exit_cnt_reg   <= '0;
            paused_reg     <= 1'b1;
            flags_reg      <= '0;
        end else if (item_advance) begin
            stage_reg      <= stage_next;
            poll_timer_reg <= poll_timer_next;
            refresh_reg    <= refresh_next;
            exit_cnt_reg   <= exit_cnt_next;
            paused_reg     <= paused_next;
            flags_reg      <= flags_next;
        end
    end

    always_comb begin
        result.stage_now           = stage_next;
        result.flags               = flags_next;
        result.capture_request     = cap;
        result.out_of_paper_notice = oop;
        result.jam_report          = jam;
        result.awaiting_host       = paused_next;
    end

endmodule

`default_nettype wire

@@ src/paper_feed_sequencer.sv @@
// Channel   Direction  tdata (lowest bit up)                         tuser
// s_        in         sensor_entry, sensor_middle, sensor_exit,      kind
//                      front_turning, rear_turning, 3 zero bits
// m_        out        stage_now[2:0], front_motor_on, rear_motor_on, -
//                      flash_led, direction_led, fault_led,
//                      capture_request, out_of_paper_notice,
//                      jam_report, awaiting_host, 4 zero bits
// cfg_      in         write enable, register index, 16-bit value     -
//
// One transfer is accepted every cycle while the result register is not stalled; each result
// is computed from the input register and held in the result register. The throughput is
// set by the state update between the input register and the result register.
// Synchronous active-low reset restores the register defaults and the idle, paused state.
// A stalled result register holds its transfer while the input register still accepts one.
`default_nettype none

module paper_feed_sequencer (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    // sensor_entry, sensor_middle, sensor_exit, front_turning, rear_turning
    input  wire logic [pfs_pkg::S_TDATA_W-1:0]  s_tdata,
    // kind
    input  wire logic                           s_tuser,
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    // stage_now[2:0], front_motor_on, rear_motor_on, flash_led, direction_led,
    // fault_led, capture_request, out_of_paper_notice, jam_report, awaiting_host
    output      logic [pfs_pkg::M_TDATA_W-1:0]  m_tdata,
    input  wire logic                           cfg_we,
    input  wire logic [pfs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [pfs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import pfs_pkg::*;

    localparam int RESULT_W = $bits(result_t);

    cfg_t    cfg;
    result_t result;
    item_t   in_item_reg, in_item_next;
    logic    in_valid_reg, in_valid_next;
    logic    out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic    advance;

    pfs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pfs_step u_step (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .item_advance (advance),
        .item         (in_item_reg),
        .result       (result)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
            in_item_next.kind          = s_tuser;
            in_item_next.sensor_entry  = s_tdata[0];
            in_item_next.sensor_middle = s_tdata[1];
            in_item_next.sensor_exit   = s_tdata[2];
            in_item_next.front_turning = s_tdata[3];
            in_item_next.rear_turning  = s_tdata[4];
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (advance) begin
            out_valid_next = 1'b1;
            out_data_next  = {(M_TDATA_W - RESULT_W)'(0), result};
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_item_reg  <= in_item_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTH
    a_capture_pauses: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> m_tdata[11])
        else $error("capture request without paused polling");

    a_jam_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[10] |-> (m_tdata[2:0] == STAGE_HALT) && m_tdata[7])
        else $error("jam report without idle stage and fault LED");

    a_notice_ejects: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9] |-> (m_tdata[2:0] == STAGE_EJECT) || m_tdata[10])
        else $error("out-of-paper notice outside the eject stage");

    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while the result register is empty");
`endif

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import pfs_pkg::*;

    localparam int RES_W        = $bits(result_t);
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 290;
    localparam int PRINT_CAP    = 40;
    localparam flags_t EJECT_MASK = flags_t'((1 << FLAG_FRONT) | (1 << FLAG_REAR)
                                             | (1 << FLAG_FLASH));

    // Sensor levels {exit, middle, entry} as one sheet moves through the transport.
    localparam logic [2:0] PAPER_TRACK [6] = '{3'b111, 3'b110, 3'b100, 3'b001, 3'b011, 3'b111};

    localparam int PHASE_POLL    [PHASES] = '{0, 3, 1, 65535, 2, 0};
    localparam int PHASE_TIMEOUT [PHASES] = '{12, 30, 0, 5, 25, 65535};
    localparam int PHASE_RETRY   [PHASES] = '{2, 1, 0, 3, 4, 65535};
    localparam int PHASE_EXIT    [PHASES] = '{0, 4, 1, 2, 7, 65535};
    localparam int PHASE_SEND    [PHASES] = '{0, 74, 0, 13, 0, 74};
    localparam int PHASE_RECV    [PHASES] = '{0, 0, 74, 13, 74, 0};

    localparam string FLAG_NAMES [FLAG_W] = '{"front_motor_on", "rear_motor_on", "flash_led",
                                              "direction_led", "fault_led"};

    typedef enum logic [0:0] {
        ROW_TRANSFER,
        ROW_CONFIG
    } row_op_t;

    typedef struct {
        row_op_t              op;
        logic                 kind;
        logic [4:0]           bits;
        logic [CFG_ADDR_W-1:0] idx;
        logic [CFG_DATA_W-1:0] value;
        logic                 typed;
        result_t              want;
    } directed_row_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    stage_t       feed_stage      = STAGE_HALT;
    logic [15:0]  feed_poll_timer = '0;
    logic [15:0]  feed_refresh    = 16'd1;
    logic [15:0]  feed_exit_count = '0;
    logic         feed_paused     = 1'b1;
    flags_t       feed_flags      = '0;

    logic [15:0]  set_poll    = POLL_PERIOD_RST;
    logic [15:0]  set_timeout = WORKFLOW_TIMEOUT_RST;
    logic [15:0]  set_retry   = RETRY_DELAY_RST;
    logic [15:0]  set_exit    = EXIT_DELAY_RST;

    result_t      expected_status [$];
    directed_row_t directed_rows  [$];

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int mismatch_count  = 0;
    int results_checked = 0;
    int items_sent      = 0;
    int settings_used   = 1;
    int captures_seen   = 0;
    int notices_seen    = 0;
    int jams_seen       = 0;

    paper_feed_sequencer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results still outstanding.", expected_status.size());
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    function automatic result_t predict_feed_step(input logic kind, input logic [4:0] bits);
        logic    ent;
        logic    mid;
        logic    ext;
        logic    ft;
        logic    rt;
        logic    cap;
        logic    oop;
        logic    jam;
        result_t r;
        ent = bits[0];
        mid = bits[1];
        ext = bits[2];
        ft  = bits[3];
        rt  = bits[4];
        cap = 1'b0;
        oop = 1'b0;
        jam = 1'b0;
        if (kind) begin
            feed_paused = 1'b0;
        end else begin
            if (feed_poll_timer != 16'hFFFF)
                feed_poll_timer++;
            if (feed_exit_count != 16'd0) begin
                feed_exit_count--;
                if (feed_exit_count == 16'd0) begin
                    feed_flags &= ~EJECT_MASK;
                    feed_stage = STAGE_WAIT;
                end
            end else begin
                if (feed_refresh != 16'd0) begin
                    feed_refresh--;
                    if (feed_refresh == 16'd0) begin
                        if (ent && mid && ext) begin
                            feed_flags  = '0;
                            feed_paused = 1'b0;
                            feed_stage  = STAGE_WAIT;
                        end else begin
                            if (!ent || !mid)
                                feed_flags[FLAG_FRONT] = 1'b1;
                            if (!ext)
                                feed_flags[FLAG_REAR] = 1'b1;
                            feed_refresh = at_least_one(set_retry);
                        end
                    end
                end
                if (!feed_paused && feed_poll_timer > set_poll) begin
                    feed_poll_timer = '0;
                    case (feed_stage)
                        STAGE_WAIT: begin
                            feed_flags[FLAG_DIR] = ~feed_flags[FLAG_DIR];
                            if (!ent) begin
                                feed_flags[FLAG_DIR]   = 1'b0;
                                feed_flags[FLAG_FRONT] = 1'b1;
                                feed_stage   = STAGE_FEED;
                                feed_refresh = at_least_one(set_timeout);
                            end
                        end
                        STAGE_FEED: begin
                            if (!ext) begin
                                feed_flags[FLAG_FRONT] = 1'b0;
                                feed_flags[FLAG_FLASH] = 1'b1;
                                cap          = 1'b1;
                                feed_paused  = 1'b1;
                                feed_stage   = STAGE_OUT;
                                feed_refresh = at_least_one(set_timeout);
                            end
                        end
                        STAGE_OUT: begin
                            if (!feed_flags[FLAG_FRONT] && !feed_flags[FLAG_REAR]) begin
                                feed_flags[FLAG_FRONT] = 1'b1;
                                feed_flags[FLAG_REAR]  = 1'b1;
                            end
                            if (ent && mid) begin
                                feed_flags[FLAG_FRONT] = 1'b0;
                                cap          = 1'b1;
                                feed_paused  = 1'b1;
                                feed_stage   = STAGE_NOTIFY;
                                feed_refresh = at_least_one(set_timeout);
                            end
                        end
                        STAGE_NOTIFY: begin
                            oop          = 1'b1;
                            feed_stage   = STAGE_EJECT;
                            feed_refresh = '0;
                        end
                        STAGE_EJECT: begin
                            if (ext) begin
                                if (set_exit == 16'd0) begin
                                    feed_flags &= ~EJECT_MASK;
                                    feed_stage = STAGE_WAIT;
                                end else begin
                                    feed_exit_count = set_exit;
                                end
                            end
                        end
                        default: ;
                    endcase
                    if (feed_exit_count == 16'd0 && feed_flags[FLAG_FRONT]
                            && feed_flags[FLAG_REAR]) begin
                        if (!(ft && rt)) begin
                            feed_flags[FLAG_FAULT] = 1'b1;
                            jam        = 1'b1;
                            feed_stage = STAGE_HALT;
                        end else begin
                            feed_flags[FLAG_FAULT] = 1'b0;
                        end
                    end
                end
            end
        end
        r.stage_now           = feed_stage;
        r.flags               = feed_flags;
        r.capture_request     = cap;
        r.out_of_paper_notice = oop;
        r.jam_report          = jam;
        r.awaiting_host       = feed_paused;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        // Printing stops after a while so that a broken block cannot flood the log.
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH at result %0d, %s: got %0d, expected %0d",
                     results_checked, what, got, want);
        mismatch_count++;
    endtask

    task automatic hold_off_sender();
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic send_transfer(input logic kind, input logic [4:0] bits, input logic typed,
                                 input result_t want);
        result_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W-5){1'b0}}, bits};
        do
            @(posedge aclk);
        while (!s_tready);
        predicted = predict_feed_step(kind, bits);
        expected_status.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic write_register(input logic [CFG_ADDR_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_POLL_PERIOD:      set_poll    = value;
            REG_WORKFLOW_TIMEOUT: set_timeout = value;
            REG_RETRY_DELAY:      set_retry   = value;
            REG_EXIT_DELAY:       set_exit    = value;
            default: ;
        endcase
    endtask

    function automatic directed_row_t transfer_row(input logic kind, input logic [4:0] bits,
                                                   input logic typed, input result_t want);
        directed_row_t row;
        row.op    = ROW_TRANSFER;
        row.kind  = kind;
        row.bits  = bits;
        row.idx   = '0;
        row.value = '0;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    function automatic directed_row_t config_row(input logic [CFG_ADDR_W-1:0] idx,
                                                 input logic [CFG_DATA_W-1:0] value);
        directed_row_t row;
        row       = transfer_row(1'b0, '0, 1'b0, '0);
        row.op    = ROW_CONFIG;
        row.idx   = idx;
        row.value = value;
        return row;
    endfunction

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[RES_W-1:0]);
            if (expected_status.size() == 0) begin
                report_mismatch("transfer with nothing expected", int'(m_tdata), 0);
            end else begin
                want = expected_status.pop_front();
                if (m_tdata[M_TDATA_W-1:RES_W] != '0)
                    report_mismatch("padding bits", int'(m_tdata[M_TDATA_W-1:RES_W]), 0);
                if (got.stage_now !== want.stage_now)
                    report_mismatch("stage_now", int'(got.stage_now), int'(want.stage_now));
                for (int b = 0; b < FLAG_W; b++) begin
                    if (got.flags[b] !== want.flags[b])
                        report_mismatch(FLAG_NAMES[b], int'(got.flags[b]), int'(want.flags[b]));
                end
                if (got.capture_request !== want.capture_request)
                    report_mismatch("capture_request", int'(got.capture_request),
                                    int'(want.capture_request));
                if (got.out_of_paper_notice !== want.out_of_paper_notice)
                    report_mismatch("out_of_paper_notice", int'(got.out_of_paper_notice),
                                    int'(want.out_of_paper_notice));
                if (got.jam_report !== want.jam_report)
                    report_mismatch("jam_report", int'(got.jam_report), int'(want.jam_report));
                if (got.awaiting_host !== want.awaiting_host)
                    report_mismatch("awaiting_host", int'(got.awaiting_host),
                                    int'(want.awaiting_host));
                captures_seen += int'(want.capture_request);
                notices_seen  += int'(want.out_of_paper_notice);
                jams_seen     += int'(want.jam_report);
                results_checked++;
            end
        end
    end

    initial begin
        result_t    after_first_tick;
        logic       kind;
        logic [2:0] sensors;
        logic [1:0] encoders;
        int         paper_pos;
        int         dwell;
        int         drain_guard;

        after_first_tick           = '0;
        after_first_tick.stage_now = STAGE_WAIT;

        // Bits are {rear_turning, front_turning, exit, middle, entry}; sensors read 0 on paper.
        directed_rows.push_back(transfer_row(1'b1, 5'b11111, 1'b1, '0));
        directed_rows.push_back(transfer_row(1'b0, 5'b11111, 1'b1, after_first_tick));
        directed_rows.push_back(transfer_row(1'b0, 5'b00000, 1'b0, '0));
        directed_rows.push_back(config_row(REG_POLL_PERIOD, 16'd0));
        directed_rows.push_back(config_row(REG_WORKFLOW_TIMEOUT, 16'd40));
        directed_rows.push_back(config_row(REG_RETRY_DELAY, 16'd1));
        directed_rows.push_back(config_row(REG_EXIT_DELAY, 16'd0));
        directed_rows.push_back(transfer_row(1'b0, 5'b11111, 1'b0, '0));
        directed_rows.push_back(transfer_row(1'b1, 5'b11111, 1'b0, '0));
        directed_rows.push_back(transfer_row(1'b0, 5'b11110, 1'b0, '0));
        directed_rows.push_back(transfer_row(1'b0, 5'b11100, 1'b0, '0));
        directed_rows.push_back(transfer_row(1'b0, 5'b11000, 1'b0, '0));
        directed_rows.push_back(transfer_row(1'b0, 5'b11000, 1'b0, '0));
        directed_rows.push_back(transfer_row(1'b1, 5'b00000, 1'b0, '0));
        directed_rows.push_back(transfer_row(1'b0, 5'b11001, 1'b0, '0));
        directed_rows.push_back(transfer_row(1'b0, 5'b11011, 1'b0, '0));
        directed_rows.push_back(transfer_row(1'b1, 5'b11111, 1'b0, '0));
        directed_rows.push_back(transfer_row(1'b0, 5'b00011, 1'b0, '0));
        directed_rows.push_back(transfer_row(1'b0, 5'b11011, 1'b0, '0));
        directed_rows.push_back(transfer_row(1'b0, 5'b11111, 1'b0, '0));
        directed_rows.push_back(transfer_row(1'b0, 5'b11110, 1'b0, '0));
        directed_rows.push_back(transfer_row(1'b0, 5'b11000, 1'b0, '0));
        directed_rows.push_back(transfer_row(1'b1, 5'b11111, 1'b0, '0));
        directed_rows.push_back(transfer_row(1'b0, 5'b01000, 1'b0, '0));
        directed_rows.push_back(transfer_row(1'b0, 5'b10111, 1'b0, '0));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].op == ROW_CONFIG) begin
                write_register(directed_rows[i].idx, directed_rows[i].value);
            end else begin
                hold_off_sender();
                send_transfer(directed_rows[i].kind, directed_rows[i].bits,
                              directed_rows[i].typed, directed_rows[i].want);
            end
        end
        settings_used++;

        paper_pos = 0;
        for (int p = 0; p < PHASES; p++) begin
            write_register(REG_POLL_PERIOD, PHASE_POLL[p][15:0]);
            write_register(REG_WORKFLOW_TIMEOUT, PHASE_TIMEOUT[p][15:0]);
            write_register(REG_RETRY_DELAY, PHASE_RETRY[p][15:0]);
            write_register(REG_EXIT_DELAY, PHASE_EXIT[p][15:0]);
            send_idle_pct  = PHASE_SEND[p];
            recv_stall_pct = PHASE_RECV[p];
            settings_used++;
            dwell = 2 * (((set_poll > 16'd6) ? 6 : int'(set_poll)) + 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                hold_off_sender();
                // The host answers a pending capture quickly, and now and then out of turn.
                if (feed_paused)
                    kind = ($urandom_range(0, 2) == 0);
                else
                    kind = ($urandom_range(0, 39) == 0);
                if ($urandom_range(0, dwell) == 0)
                    paper_pos = (paper_pos == 5) ? 0 : paper_pos + 1;
                sensors = PAPER_TRACK[paper_pos];
                if ($urandom_range(0, 9) == 0)
                    sensors = 3'($urandom_range(0, 7));
                encoders = ($urandom_range(0, 15) == 0) ? 2'($urandom_range(0, 3)) : 2'b11;
                send_transfer(kind, {encoders, sensors}, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        drain_guard = 0;
        while (expected_status.size() != 0 && drain_guard < 50000) begin
            @(posedge aclk);
            drain_guard++;
        end
        repeat (8) @(posedge aclk);
        if (expected_status.size() != 0)
            report_mismatch("results never delivered", 0, expected_status.size());

        $display("Checked %0d results of %0d transfers under %0d register settings.",
                 results_checked, items_sent, settings_used);
        $display("The paper path raised %0d captures, %0d paper-out notices and %0d jams.",
                 captures_seen, notices_seen, jams_seen);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
